@@ rtl/binary_neighbor_count_erosion_assert.svh @@
// Assertion macros for the binary neighbor-count erosion block.
// Used by the top level; needs clk and rst_n in the including scope.
`ifndef BINARY_NEIGHBOR_COUNT_EROSION_ASSERT_SVH
`define BINARY_NEIGHBOR_COUNT_EROSION_ASSERT_SVH

// Check that a condition implies a consequence at the same edge.
`define BNCE_ASSERT_NOW(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("bnce assertion failed");

// Check that a condition implies a consequence at the next edge.
`define BNCE_ASSERT_NEXT(lbl, cond, conseq) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("bnce assertion failed");

`endif

@@ rtl/bnce_pkg.sv @@
// Shared types and constants for the binary neighbor-count erosion block.
// No dependencies.
`default_nettype none
package bnce_pkg;

  localparam int MAX_WIDTH = 256;
  localparam int COL_W     = 8;
  localparam int ROW_W     = 12;
  localparam int CNT_W     = 21;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;

  // Item kinds
  localparam logic REQ_PIXEL = 1'b0;

  typedef struct packed {
    logic req_type;
    logic pixel_set;
  } in_item_t;

  typedef struct packed {
    logic [11:0] row_index;
    logic [7:0]  col_index;
    logic        was_set;
    logic [3:0]  neighbor_count;
    logic        removable;
    logic        pixel_after;
    logic [20:0] removed_count;
    logic        frame_last;
  } out_item_t;

  // One window handed from front to back
  typedef struct packed {
    logic [8:0]       window;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             col_first;
    logic             col_last;
    logic             row_first;
    logic             row_last;
    logic             frame_first;
    logic             frame_last;
  } job_t;

  typedef struct packed {
    logic              near_full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage
`default_nettype wire

@@ rtl/bnce_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bnce_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read (old data on a same-address collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/bnce_front.sv @@
// Front end: accepts items, tracks raster positions, runs the line buffers
// and the 3x3 window, and hands windows to the queue. Uses bnce_pkg, bnce_ram.
`default_nettype none
module bnce_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  bnce_pkg::in_item_t in_item,
  output logic              in_full,
  input  logic [8:0]        w_eff,
  input  logic [12:0]       h_eff,
  input  logic              restart,
  input  bnce_pkg::qstat_t  qstat,
  output logic              job_push,
  output bnce_pkg::job_t    job
);
  import bnce_pkg::*;

  logic             accept;
  logic             px0;
  logic             in_col_wrap;
  logic             emit;
  logic             orow_last;
  logic             ocol_last;
  logic             last;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [12:0]      in_row_r, in_row_nxt;
  logic [8:0]       fill_r, fill_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;

  logic             s1_valid_r;
  logic             s1_emit_r;
  logic             s1_px_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_orow_r;
  logic [COL_W-1:0] s1_ocol_r;
  logic             s1_cfirst_r, s1_clast_r, s1_rfirst_r, s1_rlast_r;
  logic             s1_ffirst_r, s1_flast_r;
  logic             fwd_r;
  logic [1:0]       fwd_data_r;
  logic [8:0]       win_r, win_nxt;

  logic [1:0]       ram_rd;
  logic [1:0]       line;
  logic [1:0]       line_wr;

  // Stage 0: accept and position bookkeeping
  assign in_full   = qstat.near_full;
  assign accept    = in_push & ~in_full;
  assign px0       = (in_item.req_type == REQ_PIXEL) & in_item.pixel_set &
                     (in_row_r < h_eff);
  assign in_col_wrap = ({1'b0, in_col_r} + 9'd1) >= w_eff;
  assign emit      = {1'b0, fill_r} >= ({1'b0, w_eff} + 10'd1);
  assign orow_last = ({1'b0, out_row_r} + 13'd1) >= h_eff;
  assign ocol_last = ({1'b0, out_col_r} + 9'd1) >= w_eff;
  assign last      = orow_last & ocol_last;

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    fill_nxt    = fill_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (restart) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      fill_nxt    = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (accept) begin
      if (in_col_wrap) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 13'd1;
      end else begin
        in_col_nxt = in_col_r + 8'd1;
      end
      if (!emit) begin
        fill_nxt = fill_r + 9'd1;
      end
      if (emit) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          fill_nxt    = '0;
          out_row_nxt = '0;
          out_col_nxt = '0;
        end else if (ocol_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 12'd1;
        end else begin
          out_col_nxt = out_col_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      fill_r     <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      fill_r     <= fill_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      s1_valid_r <= accept;
      if (accept) begin
        fwd_r <= s1_valid_r && (s1_col_r == in_col_r);
      end
    end
  end

  // Stage 1 payload: position flags of the centre that this item completes
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit_r   <= emit;
      s1_px_r     <= px0;
      s1_col_r    <= in_col_r;
      s1_orow_r   <= out_row_r;
      s1_ocol_r   <= out_col_r;
      s1_cfirst_r <= (out_col_r == '0);
      s1_clast_r  <= ocol_last;
      s1_rfirst_r <= (out_row_r == '0);
      s1_rlast_r  <= orow_last;
      s1_ffirst_r <= (out_row_r == '0) && (out_col_r == '0);
      s1_flast_r  <= last;
      fwd_data_r  <= line_wr;
    end
    if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // Line buffers: bit 0 upper line, bit 1 middle line
  bnce_ram #(.WIDTH(2), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (line_wr),
    .re    (accept),
    .raddr (in_col_r),
    .rdata (ram_rd)
  );

  // Stage 1: forward a write that collided with the read, shift the window
  assign line    = fwd_r ? fwd_data_r : ram_rd;
  assign line_wr = {s1_px_r, line[1]};
  assign win_nxt = {s1_px_r, line[1], line[0], win_r[8:3]};

  assign job_push        = s1_valid_r & s1_emit_r;
  assign job.window      = win_nxt;
  assign job.row         = s1_orow_r;
  assign job.col         = s1_ocol_r;
  assign job.col_first   = s1_cfirst_r;
  assign job.col_last    = s1_clast_r;
  assign job.row_first   = s1_rfirst_r;
  assign job.row_last    = s1_rlast_r;
  assign job.frame_first = s1_ffirst_r;
  assign job.frame_last  = s1_flast_r;

endmodule
`default_nettype wire

@@ rtl/bnce_queue.sv @@
// Short queue of windows between front and back ends.
// Uses bnce_pkg.
`default_nettype none
module bnce_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bnce_pkg::job_t   push_job,
  input  logic             pop,
  output bnce_pkg::job_t   head,
  output bnce_pkg::qstat_t qstat
);
  import bnce_pkg::*;

  job_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign do_pop          = pop & (count_r != '0);
  assign head            = slots_r[rd_ptr_r];
  assign qstat.count     = count_r;
  assign qstat.empty     = (count_r == '0);
  assign qstat.near_full = count_r >= QCNT_W'(QDEPTH - 1);

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ rtl/bnce_back.sv @@
// Back end: counts neighbors, applies the threshold, keeps the frame total
// and holds the result register. Uses bnce_pkg.
`default_nettype none
module bnce_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bnce_pkg::job_t     head,
  input  bnce_pkg::qstat_t   qstat,
  output logic               q_pop,
  input  logic [3:0]         threshold,
  output logic               out_empty,
  input  logic               out_pop,
  output bnce_pkg::out_item_t out_item
);
  import bnce_pkg::*;

  logic             out_valid_r;
  logic             load;
  logic [8:0]       mask;
  logic [3:0]       cnt;
  logic             was;
  logic             rem;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] acc_r;
  out_item_t        out_r;

  // Drop out-of-grid neighbors and the centre
  always_comb begin
    mask = 9'h1EF;
    if (head.col_first) mask = mask & ~9'h007;
    if (head.col_last)  mask = mask & ~9'h1C0;
    if (head.row_first) mask = mask & ~9'h049;
    if (head.row_last)  mask = mask & ~9'h124;
  end

  assign cnt   = 4'($countones(head.window & mask));
  assign was   = head.window[4];
  assign rem   = was & (cnt < threshold);
  assign total = (head.frame_first ? '0 : acc_r) + CNT_W'(rem);

  assign load  = ~out_valid_r | out_pop;
  assign q_pop = load & ~qstat.empty;

  // Advance the result register and the running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= ~qstat.empty;
      end
      if (q_pop) begin
        acc_r <= total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r.row_index      <= head.row;
      out_r.col_index      <= head.col;
      out_r.was_set        <= was;
      out_r.neighbor_count <= cnt;
      out_r.removable      <= rem;
      out_r.pixel_after    <= was & ~rem;
      out_r.removed_count  <= total;
      out_r.frame_last     <= head.frame_last;
    end
  end

  assign out_empty = ~out_valid_r;
  assign out_item  = out_r;

endmodule
`default_nettype wire

@@ rtl/binary_neighbor_count_erosion.sv @@
// Top level of the binary 3x3 neighbor-count erosion block: configuration
// registers, front end, window queue, back end. Uses bnce_pkg and submodules.
//
//   port group  direction  handshake         payload
//   in_         in         in_push/in_full   in_item (req_type, pixel_set)
//   out_        out        out_pop/out_empty out_item (position, count, flags)
//   cfg_        in         cfg_we            cfg_index, cfg_data
//
// One item per cycle sustained while in_full is low. A centre's result
// reaches the out_ ports after the item completing its window is accepted
// (line-buffer read, window shift into the queue, count into result register).
// Results lag by one row and one pixel, so a frame needs grid_width + 1
// trailing flush items. Synchronous active-low reset; no clearing pass.
// in_full rises once three windows wait in the four-entry queue, so the input
// keeps flowing through short result-side stalls.
`default_nettype none
module binary_neighbor_count_erosion (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  bnce_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output bnce_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_data
);
  import bnce_pkg::*;

  logic [8:0]  width_r;
  logic [12:0] height_r;
  logic [3:0]  thresh_r;
  logic [8:0]  w_eff;
  logic [12:0] h_eff;
  logic        cfg_hit;
  logic        job_push;
  logic        q_pop;
  logic        out_at_origin;
  job_t        job;
  job_t        head;
  qstat_t      qstat;

  // Hold configuration registers
  assign cfg_hit = cfg_we && (cfg_index == REG_GRID_WIDTH ||
                              cfg_index == REG_GRID_HEIGHT ||
                              cfg_index == REG_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 13'd256;
      thresh_r <= 4'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  width_r  <= cfg_data[8:0];
        REG_GRID_HEIGHT: height_r <= cfg_data;
        REG_THRESHOLD:   thresh_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Clamp raster dimensions
  always_comb begin
    w_eff = width_r;
    if (width_r == '0) w_eff = 9'd1;
    if (width_r > 9'(MAX_WIDTH)) w_eff = 9'(MAX_WIDTH);
    h_eff = height_r;
    if (height_r == '0) h_eff = 13'd1;
    if (height_r > 13'd4096) h_eff = 13'd4096;
  end

  bnce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .restart  (cfg_hit),
    .qstat    (qstat),
    .job_push (job_push),
    .job      (job)
  );

  bnce_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .head     (head),
    .qstat    (qstat)
  );

  bnce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qstat     (qstat),
    .q_pop     (q_pop),
    .threshold (thresh_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  // Result for the first centre of a frame
  assign out_at_origin = !out_empty && out_item.row_index == '0 &&
                         out_item.col_index == '0;

  `include "binary_neighbor_count_erosion_assert.svh"

  `BNCE_ASSERT_NOW(a_queue_bound, 1'b1, qstat.count <= QCNT_W'(QDEPTH))
  `BNCE_ASSERT_NOW(a_no_push_full, job_push, qstat.count < QCNT_W'(QDEPTH) || q_pop)
  `BNCE_ASSERT_NOW(a_frame_start_total, out_at_origin, out_item.removed_count == 21'(out_item.removable))
  `BNCE_ASSERT_NEXT(a_pop_moves, q_pop && !qstat.empty, !out_empty)

endmodule
`default_nettype wire
